@@ design/swdm_pkg.sv @@
// Package: modes, request codes, register indexes, payload and state types for the display sequencer.
package swdm_pkg;

    typedef enum logic [2:0] {
        MODE_CLOCK    = 3'd0,
        MODE_COUNTIN  = 3'd1,
        MODE_RUNNING  = 3'd2,
        MODE_FLASHING = 3'd3,
        MODE_RESULT   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_PRESS = 2'd1,
        FUNC_TIME  = 2'd2,
        FUNC_SET   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_BLINK_LEN       = 3'd0,
        CFG_HOLD_LEN        = 3'd1,
        CFG_MAX_ELAPSED     = 3'd2,
        CFG_LOCKOUT_MS      = 3'd3,
        CFG_COUNTDOWN_START = 3'd4
    } cfg_idx_t;

    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned TOGGLE_TICKS = 8;
    localparam int unsigned SECOND_TICKS = 2;

    localparam logic [7:0]  BLINK_LEN_RST       = 8'd16;
    localparam logic [15:0] HOLD_LEN_RST        = 16'd120;
    localparam logic [15:0] MAX_ELAPSED_RST     = 16'd6000;
    localparam logic [15:0] LOCKOUT_MS_RST      = 16'd200;
    localparam logic [3:0]  COUNTDOWN_START_RST = 4'd3;

    typedef struct packed {
        logic [7:0]  blink_len;
        logic [15:0] hold_len;
        logic [15:0] max_elapsed;
        logic [15:0] lockout_ms;
        logic [3:0]  countdown_start;
    } cfg_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] now_ms;
        logic        minute_changed;
        logic        date_changed;
        logic [2:0]  new_mode;
    } cmd_t;

    typedef struct packed {
        mode_t       mode_now;
        logic        showing_time;
        logic [1:0]  top_row_select;
        logic [3:0]  countdown_value;
        logic [15:0] elapsed_seconds;
        logic        flash_visible;
        logic        refresh;
        logic        restart_tick_phase;
        logic        press_accepted;
    } res_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] tick;
        logic        time_not_date;
        logic [1:0]  top_row;
        logic [3:0]  countdown;
        logic [15:0] elapsed;
        logic        flash_phase;
        logic [31:0] last_press_ms;
    } state_t;

    localparam state_t STATE_RST = '{
        mode:          MODE_CLOCK,
        tick:          16'd0,
        time_not_date: 1'b1,
        top_row:       2'd0,
        countdown:     COUNTDOWN_START_RST,
        elapsed:       16'd0,
        flash_phase:   1'b1,
        last_press_ms: 32'd0
    };

    // Return to normal: keep only the press time stamp
    function automatic state_t go_normal(state_t s, logic [3:0] cd_start);
        state_t r;
        r               = s;
        r.mode          = MODE_CLOCK;
        r.time_not_date = 1'b1;
        r.tick          = 16'd0;
        r.top_row       = 2'd0;
        r.elapsed       = 16'd0;
        r.countdown     = cd_start;
        r.flash_phase   = 1'b1;
        return r;
    endfunction

    // Rotate time, date, temperature
    function automatic logic [1:0] next_row(logic [1:0] row);
        logic [1:0] r;
        case (row)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ design/swdm_chan_if.sv @@
// Interface: valid/ready channel carrying one request or result payload.
interface swdm_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/swdm_core.sv @@
// Module: next-state and result logic for one request of the display sequencer.
module swdm_core
    import swdm_pkg::*;
(
    input  state_t state,
    input  cfg_t   cfg,
    input  cmd_t   item,
    output state_t state_next,
    output res_t   res
);

    state_t      s;
    logic [15:0] t1;
    logic        second;
    logic        toggle;
    logic [16:0] el_inc;
    logic [31:0] gap;
    logic        refresh;
    logic        restart;
    logic        accepted;

    always_comb
    begin
        s        = state;
        refresh  = 1'b0;
        restart  = 1'b0;
        accepted = 1'b0;
        t1       = state.tick + 16'd1;
        second   = (t1 % 16'(SECOND_TICKS)) == 16'd0;
        toggle   = (t1 % 16'(TOGGLE_TICKS)) == 16'd0;
        el_inc   = {1'b0, state.elapsed} + 17'd1;
        gap      = item.now_ms - state.last_press_ms;

        case (item.func)
            FUNC_TICK:
            begin
                s.tick = t1;
                if (state.mode != MODE_CLOCK && toggle)
                begin
                    s.top_row = next_row(state.top_row);
                    refresh   = 1'b1;
                end
                unique case (state.mode)
                    MODE_CLOCK:
                    begin
                        if (toggle)
                        begin
                            s.time_not_date = ~state.time_not_date;
                            refresh         = 1'b1;
                        end
                    end
                    MODE_COUNTIN:
                    begin
                        if (t1 > 16'd1 && second)
                        begin
                            refresh = 1'b1;
                            if (state.countdown <= 4'd1)
                            begin
                                s.countdown = 4'd0;
                                s.mode      = MODE_RUNNING;
                                s.elapsed   = 16'd0;
                                s.top_row   = 2'd0;
                                s.tick      = 16'd0;
                            end
                            else
                            begin
                                s.countdown = state.countdown - 4'd1;
                            end
                        end
                    end
                    MODE_RUNNING:
                    begin
                        if (t1 > 16'd1 && second)
                        begin
                            refresh = 1'b1;
                            if (el_inc >= {1'b0, cfg.max_elapsed} || el_inc[16])
                                s = go_normal(s, cfg.countdown_start);
                            else
                                s.elapsed = el_inc[15:0];
                        end
                    end
                    MODE_FLASHING:
                    begin
                        s.flash_phase = ~state.flash_phase;
                        refresh       = 1'b1;
                        if (t1 >= {8'd0, cfg.blink_len})
                        begin
                            s.mode = MODE_RESULT;
                            s.tick = 16'd0;
                        end
                    end
                    MODE_RESULT:
                    begin
                        if (second)
                            refresh = 1'b1;
                        if (t1 >= cfg.hold_len)
                        begin
                            s       = go_normal(s, cfg.countdown_start);
                            refresh = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_PRESS:
            begin
                if (gap >= {16'd0, cfg.lockout_ms})
                begin
                    accepted        = 1'b1;
                    s.last_press_ms = item.now_ms;
                    unique case (state.mode)
                        MODE_CLOCK, MODE_RESULT:
                        begin
                            s.mode      = MODE_COUNTIN;
                            s.countdown = cfg.countdown_start;
                            s.top_row   = 2'd0;
                            s.tick      = 16'd0;
                            refresh     = 1'b1;
                            restart     = 1'b1;
                        end
                        MODE_COUNTIN:
                        begin
                            s       = go_normal(s, cfg.countdown_start);
                            refresh = 1'b1;
                            restart = 1'b1;
                        end
                        MODE_RUNNING:
                        begin
                            s.mode        = MODE_FLASHING;
                            s.flash_phase = 1'b1;
                            s.tick        = 16'd0;
                            refresh       = 1'b1;
                            restart       = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FUNC_TIME:
            begin
                if (state.mode == MODE_CLOCK)
                    refresh = (item.minute_changed && state.time_not_date) ||
                              (item.date_changed && !state.time_not_date);
                else if (state.mode == MODE_FLASHING || state.mode == MODE_RESULT)
                    refresh = item.minute_changed;
            end
            default:
            begin
                // Direct set; ignore codes past the last mode
                if (item.new_mode <= MODE_RESULT && item.new_mode != state.mode)
                begin
                    s.mode = mode_t'(item.new_mode);
                    s.tick = 16'd0;
                end
            end
        endcase

        state_next             = s;
        res.mode_now           = s.mode;
        res.showing_time       = s.time_not_date;
        res.top_row_select     = s.top_row;
        res.countdown_value    = s.countdown;
        res.elapsed_seconds    = s.elapsed;
        res.flash_visible      = s.flash_phase;
        res.refresh            = refresh;
        res.restart_tick_phase = restart;
        res.press_accepted     = accepted;
    end

endmodule

@@ design/stopwatch_display_mode_controller.sv @@
// Top level: stopwatch display mode sequencer with request and result channels.
//
//  Channel   Dir   Handshake        Payload
//  cmd       in    valid / ready    cmd_t: func, now_ms, minute/date flags, new_mode
//  res       out   valid / ready    res_t: mode and display state, refresh, restart, press flag
//  cfg_*     in    cfg_we only      cfg_index (3 bit), cfg_wdata (16 bit)
//
// One request a cycle sustained while the result side keeps taking results. A request
// taken sits in the input register; when it advances, the state update and the result
// register load happen together, and the result is then valid on the result channel.
// Reset clears all state and restores the register defaults; no clearing pass.
// A stalled result holds the result register and then the input register; the
// request side stalls only once both are full.
module stopwatch_display_mode_controller
    import swdm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    swdm_chan_if.sink              cmd,
    swdm_chan_if.source            res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    logic   in_valid_reg;
    cmd_t   in_reg;
    logic   out_valid_reg;
    res_t   out_reg;
    res_t   core_res;
    logic   advance;

    // Move the held request into the result register when that slot frees up
    assign advance     = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready   = !in_valid_reg || advance;
    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;

    // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_len       <= BLINK_LEN_RST;
            cfg_reg.hold_len        <= HOLD_LEN_RST;
            cfg_reg.max_elapsed     <= MAX_ELAPSED_RST;
            cfg_reg.lockout_ms      <= LOCKOUT_MS_RST;
            cfg_reg.countdown_start <= COUNTDOWN_START_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLINK_LEN:       cfg_reg.blink_len       <= cfg_wdata[7:0];
                CFG_HOLD_LEN:        cfg_reg.hold_len        <= cfg_wdata;
                CFG_MAX_ELAPSED:     cfg_reg.max_elapsed     <= cfg_wdata;
                CFG_LOCKOUT_MS:      cfg_reg.lockout_ms      <= cfg_wdata;
                CFG_COUNTDOWN_START: cfg_reg.countdown_start <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: hold the request until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.valid && cmd.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            in_reg <= cmd.payload;
    end

    swdm_core u_core (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_reg),
        .state_next (state_next),
        .res        (core_res)
    );

    // State and result register update together, once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RST;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_res;
    end

    // The result register always reflects the mode just committed
    a_mode_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_reg.mode_now == state_reg.mode)
        else $error("result mode differs from committed state");

    // A waiting request must not be lost or altered while the result side stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("held request dropped or changed");

    // Back-pressure on requests only when a request and a result are both held
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> in_valid_reg && out_valid_reg)
        else $error("request side stalled with free space");

    // An accepted press records its time stamp
    a_press_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_res.press_accepted |=>
            state_reg.last_press_ms == $past(in_reg.now_ms))
        else $error("accepted press time not recorded");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stopwatch display mode sequencer: request stream, result checks.
module tb_top;
    import swdm_pkg::*;

    // Run shape
    localparam int PHASE_REQS  = 233;
    localparam int PHASES      = 7;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;      // settling margin after the last result
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the display sequencer state and keeps the displays still owed by the block.
    class display_tracker;
        // Register copies
        logic [7:0]  blink_len;
        logic [15:0] hold_len;
        logic [15:0] max_elapsed;
        logic [15:0] lockout_ms;
        logic [3:0]  countdown_start;
        // Sequencer state
        mode_t       mode;
        logic [15:0] tick;
        logic        time_not_date;
        logic [1:0]  top_row;
        logic [3:0]  countdown;
        logic [15:0] elapsed;
        logic        flash_phase;
        logic [31:0] last_press;

        res_t expected_displays[$];
        int   errors;
        int   checked;
        int   requests;
        int   presses_taken;
        int   mode_seen[5];

        function new();
            blink_len       = BLINK_LEN_RST;
            hold_len        = HOLD_LEN_RST;
            max_elapsed     = MAX_ELAPSED_RST;
            lockout_ms      = LOCKOUT_MS_RST;
            countdown_start = COUNTDOWN_START_RST;
            mode            = MODE_CLOCK;
            tick            = '0;
            time_not_date   = 1'b1;
            top_row         = '0;
            countdown       = COUNTDOWN_START_RST;
            elapsed         = '0;
            flash_phase     = 1'b1;
            last_press      = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_BLINK_LEN:       blink_len = v[7:0];
                CFG_HOLD_LEN:        hold_len = v;
                CFG_MAX_ELAPSED:     max_elapsed = v;
                CFG_LOCKOUT_MS:      lockout_ms = v;
                CFG_COUNTDOWN_START: countdown_start = v[3:0];
                default:             ;
            endcase
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction

        function void back_to_normal();
            mode          = MODE_CLOCK;
            time_not_date = 1'b1;
            tick          = '0;
            top_row       = '0;
            elapsed       = '0;
            countdown     = countdown_start;
            flash_phase   = 1'b1;
        endfunction

        // Rotate the top row every toggle period; report whether it moved
        function bit rotate_row();
            if (tick[2:0] == 3'd0)
            begin
                top_row = (top_row == 2'd2) ? 2'd0 : top_row + 2'd1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit advance_tick();
            bit refresh;
            refresh = 1'b0;
            tick    = tick + 16'd1;
            case (mode)
                MODE_CLOCK:
                begin
                    if (tick[2:0] == 3'd0)
                    begin
                        time_not_date = ~time_not_date;
                        refresh       = 1'b1;
                    end
                end
                MODE_COUNTIN:
                begin
                    if (rotate_row())
                        refresh = 1'b1;
                    if (tick > 16'd1 && !tick[0])
                    begin
                        refresh = 1'b1;
                        if (countdown <= 4'd1)
                        begin
                            countdown = '0;
                            mode      = MODE_RUNNING;
                            elapsed   = '0;
                            top_row   = '0;
                            tick      = '0;
                        end
                        else
                            countdown = countdown - 4'd1;
                    end
                end
                MODE_RUNNING:
                begin
                    if (rotate_row())
                        refresh = 1'b1;
                    if (tick > 16'd1 && !tick[0])
                    begin
                        refresh = 1'b1;
                        // 17-bit sum also covers running past the top of the count
                        if ({1'b0, elapsed} + 17'd1 >= {1'b0, max_elapsed})
                            back_to_normal();
                        else
                            elapsed = elapsed + 16'd1;
                    end
                end
                MODE_FLASHING:
                begin
                    if (rotate_row())
                        refresh = 1'b1;
                    flash_phase = ~flash_phase;
                    refresh     = 1'b1;
                    if (tick >= {8'd0, blink_len})
                    begin
                        mode = MODE_RESULT;
                        tick = '0;
                    end
                end
                MODE_RESULT:
                begin
                    if (rotate_row())
                        refresh = 1'b1;
                    if (!tick[0])
                        refresh = 1'b1;
                    if (tick >= hold_len)
                    begin
                        back_to_normal();
                        refresh = 1'b1;
                    end
                end
                default: ;
            endcase
            return refresh;
        endfunction

        // Work out the display that an accepted request must produce
        function void note_request(cmd_t c);
            res_t r;
            bit   refresh;
            bit   restart;
            bit   taken;
            refresh = 1'b0;
            restart = 1'b0;
            taken   = 1'b0;
            requests++;
            case (c.func)
                FUNC_TICK:
                    refresh = advance_tick();
                FUNC_PRESS:
                begin
                    if (c.now_ms - last_press >= {16'd0, lockout_ms})
                    begin
                        taken      = 1'b1;
                        last_press = c.now_ms;
                        presses_taken++;
                        case (mode)
                            MODE_CLOCK, MODE_RESULT:
                            begin
                                mode      = MODE_COUNTIN;
                                countdown = countdown_start;
                                top_row   = '0;
                                tick      = '0;
                                refresh   = 1'b1;
                                restart   = 1'b1;
                            end
                            MODE_COUNTIN:
                            begin
                                back_to_normal();
                                refresh = 1'b1;
                                restart = 1'b1;
                            end
                            MODE_RUNNING:
                            begin
                                mode        = MODE_FLASHING;
                                flash_phase = 1'b1;
                                tick        = '0;
                                refresh     = 1'b1;
                                restart     = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                FUNC_TIME:
                begin
                    if (mode == MODE_CLOCK)
                    begin
                        if ((c.minute_changed && time_not_date) ||
                            (c.date_changed && !time_not_date))
                            refresh = 1'b1;
                    end
                    else if (mode == MODE_FLASHING || mode == MODE_RESULT)
                    begin
                        if (c.minute_changed)
                            refresh = 1'b1;
                    end
                end
                default:
                begin
                    // Mode codes above held result are dropped
                    if (c.new_mode <= MODE_RESULT && c.new_mode != mode)
                    begin
                        mode = mode_t'(c.new_mode);
                        tick = '0;
                    end
                end
            endcase
            r.mode_now           = mode;
            r.showing_time       = time_not_date;
            r.top_row_select     = top_row;
            r.countdown_value    = countdown;
            r.elapsed_seconds    = elapsed;
            r.flash_visible      = flash_phase;
            r.refresh            = refresh;
            r.restart_tick_phase = restart;
            r.press_accepted     = taken;
            expected_displays.push_back(r);
            mode_seen[int'(mode)]++;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s: expected %0h, got %0h", field, want, got);
            end
        endfunction

        function void check_display(res_t got);
            res_t want;
            if (expected_displays.size() == 0)
            begin
                errors++;
                $error("display with no request outstanding: mode_now %0d", got.mode_now);
                return;
            end
            want = expected_displays.pop_front();
            checked++;
            compare("mode_now", 32'(want.mode_now), 32'(got.mode_now));
            compare("showing_time", 32'(want.showing_time), 32'(got.showing_time));
            compare("top_row_select", 32'(want.top_row_select), 32'(got.top_row_select));
            compare("countdown_value", 32'(want.countdown_value), 32'(got.countdown_value));
            compare("elapsed_seconds", 32'(want.elapsed_seconds), 32'(got.elapsed_seconds));
            compare("flash_visible", 32'(want.flash_visible), 32'(got.flash_visible));
            compare("refresh", 32'(want.refresh), 32'(got.refresh));
            compare("restart_tick_phase", 32'(want.restart_tick_phase),
                    32'(got.restart_tick_phase));
            compare("press_accepted", 32'(want.press_accepted), 32'(got.press_accepted));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    swdm_chan_if #(.payload_t(cmd_t)) cmd_ch ();
    swdm_chan_if #(.payload_t(res_t)) res_ch ();

    display_tracker tracker = new();

    // Sender and receiver shaping, set per phase by the main sequence
    int burst_left;
    int burst_max;
    int gap_max;
    int recv_style;
    int hold_seq;
    int cycles;
    int input_stalls;

    stopwatch_display_mode_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: give up well beyond the slowest legal run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Monitor: predict on every accepted request, check every accepted result.
    // Sampling at the rising edge sees the values from before the block updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                tracker.note_request(cmd_ch.payload);
            if (cmd_ch.valid && !cmd_ch.ready)
                input_stalls++;
            if (res_ch.valid && res_ch.ready)
                tracker.check_display(res_ch.payload);
        end
    end

    // Receiver: drives ready at the falling edge on a pattern of its own.
    // A bump of hold_seq asks for one long hold-off, counted here.
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        int rcyc;
        hold_left    = 0;
        hold_seen    = 0;
        rcyc         = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rcyc++;
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (recv_style)
                    1:       res_ch.ready <= ($urandom_range(0, 99) < 70);
                    2:       res_ch.ready <= ((rcyc % 13) >= 5);
                    default: res_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic cmd_t req(func_t f, logic [31:0] now, logic m, logic d,
                                 logic [2:0] nm);
        cmd_t c;
        c.func           = f;
        c.now_ms         = now;
        c.minute_changed = m;
        c.date_changed   = d;
        c.new_mode       = nm;
        return c;
    endfunction

    // Random request: mostly ticks, presses placed around the lockout window,
    // some time changes and mode sets. Unused fields carry random bits too.
    function automatic cmd_t random_req();
        cmd_t        c;
        int          pick;
        logic [31:0] lock;
        lock = {16'd0, tracker.lockout_ms};
        c    = req(FUNC_TICK, $urandom(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        pick = $urandom_range(0, 99);
        if (pick >= 95)
            c.func = FUNC_SET;
        else if (pick >= 88)
            c.func = FUNC_TIME;
        else if (pick >= 78)
        begin
            c.func = FUNC_PRESS;
            case ($urandom_range(0, 9))
                0:       ;                                   // any time stamp at all
                1:       c.now_ms = tracker.last_press + lock;
                2:       c.now_ms = tracker.last_press + lock - 32'd1;
                default: c.now_ms = tracker.last_press + $urandom_range(0, 2 * lock + 50);
            endcase
        end
        return c;
    endfunction

    // Offer one request and hold it until taken. Called and returns at a falling edge;
    // valid stays high between requests of one burst.
    task automatic push_req(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, burst_max);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and hold until every result is back, then let the pipe settle
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        tracker.set_reg(idx, v);
        @(negedge clk);
    endtask

    // Write all five registers back to back; only while the block is idle
    task automatic load_settings(input logic [15:0] f, r, m, l, c);
        write_reg(CFG_BLINK_LEN, f);
        write_reg(CFG_HOLD_LEN, r);
        write_reg(CFG_MAX_ELAPSED, m);
        write_reg(CFG_LOCKOUT_MS, l);
        write_reg(CFG_COUNTDOWN_START, c);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : main_seq
        int p;
        int i;
        cycles         = 0;
        input_stalls   = 0;
        hold_seq       = 0;
        burst_left     = 0;
        burst_max      = 4;
        gap_max        = 3;
        recv_style     = 1;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.payload = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk with the reset settings
        push_req(req(FUNC_PRESS, 32'd5, 1'b0, 1'b0, 3'd0));      // inside lockout after reset
        push_req(req(FUNC_TIME, 32'd0, 1'b1, 1'b0, 3'd0));       // minute while showing time
        push_req(req(FUNC_TIME, 32'd0, 1'b0, 1'b1, 3'd0));       // date while showing time
        push_req(req(FUNC_PRESS, 32'd200, 1'b0, 1'b0, 3'd0));    // exactly at lockout
        push_req(req(FUNC_PRESS, 32'd399, 1'b0, 1'b0, 3'd0));    // one short of lockout
        repeat (6) push_req(req(FUNC_TICK, 32'd0, 1'b0, 1'b0, 3'd0));  // count down into timer
        repeat (2) push_req(req(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7));
        push_req(req(FUNC_PRESS, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'd0));    // timer to flashing
        push_req(req(FUNC_TIME, 32'd0, 1'b1, 1'b0, 3'd0));
        repeat (2) push_req(req(FUNC_TICK, 32'd0, 1'b0, 1'b0, 3'd0));
        push_req(req(FUNC_SET, 32'd0, 1'b0, 1'b0, MODE_RESULT));
        push_req(req(FUNC_SET, 32'd0, 1'b0, 1'b0, 3'd7));               // undefined code
        push_req(req(FUNC_SET, 32'd0, 1'b0, 1'b0, MODE_RESULT));        // same mode again
        push_req(req(FUNC_TIME, 32'd0, 1'b1, 1'b1, 3'd0));
        push_req(req(FUNC_PRESS, 32'h0000_0100, 1'b0, 1'b0, 3'd0));    // stamp wraps past zero
        push_req(req(FUNC_PRESS, 32'h0000_01C8, 1'b0, 1'b0, 3'd0));    // countdown back out
        push_req(req(FUNC_SET, 32'd0, 1'b0, 1'b0, MODE_RUNNING));
        wait_drained();

        // Random phases, one setting of the registers each
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings(16'd1, 16'd1, 16'd1, 16'd0, 16'd1);
                1: load_settings(16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15);
                6: load_settings(16'(BLINK_LEN_RST), HOLD_LEN_RST, MAX_ELAPSED_RST,
                                 LOCKOUT_MS_RST, 16'(COUNTDOWN_START_RST));
                default: load_settings(16'($urandom_range(1, 12)), 16'($urandom_range(1, 30)),
                                       16'($urandom_range(1, 12)), 16'($urandom_range(0, 1000)),
                                       16'($urandom_range(1, 6)));
            endcase
            case (p)
                0:       begin burst_max = 1000; gap_max = 0;  recv_style = 0; end
                1:       begin burst_max = 6;    gap_max = 4;  recv_style = 1; end
                2:       begin burst_max = 1000; gap_max = 0;  recv_style = 1; end
                3:       begin burst_max = 3;    gap_max = 10; recv_style = 2; end
                4:       begin burst_max = 8;    gap_max = 2;  recv_style = 1; end
                5:       begin burst_max = 5;    gap_max = 6;  recv_style = 2; end
                default: begin burst_max = 12;   gap_max = 3;  recv_style = 0; end
            endcase
            // Starve the result side while requests keep coming, so the block backs up
            if (p == 2)
                hold_seq++;
            for (i = 0; i < PHASE_REQS; i++)
            begin
                push_req(random_req());
                // Pause the sender mid-phase until every display is back
                if (p == 4 && i == PHASE_REQS / 2)
                    wait_drained();
            end
            wait_drained();
        end

        $display("Covered %0d requests, %0d displays checked, %0d presses accepted, %0d input stalls.",
                 tracker.requests, tracker.checked, tracker.presses_taken, input_stalls);
        $display("Steps ending in normal %0d, countdown %0d, timer %0d, flashing %0d, held %0d.",
                 tracker.mode_seen[0], tracker.mode_seen[1], tracker.mode_seen[2],
                 tracker.mode_seen[3], tracker.mode_seen[4]);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
design/swdm_pkg.sv
design/swdm_chan_if.sv
design/swdm_core.sv
design/stopwatch_display_mode_controller.sv
sim/tb_top.sv
